// ===== rtl/core/lep_pkg.sv =====
// shared types and constants of the log entry stream parser
`timescale 1ns / 1ps
`default_nettype none

package lep_pkg;

  // entry magic bytes
  localparam logic [7:0] MAGIC_0 = 8'h57;
  localparam logic [7:0] MAGIC_1 = 8'h32;

  // register reset value
  localparam logic [7:0] VERSION_RESET = 8'd1;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_REC    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TAIL    = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;
  localparam logic [1:0] ST_CLEAN   = 2'd3;

  // parser phases
  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_TIME  = 3'd1,
    PH_TYPE  = 3'd2,
    PH_KLEN  = 3'd3,
    PH_KEY   = 3'd4,
    PH_RLEN  = 3'd5,
    PH_REC   = 3'd6
  } phase_t;

  // one result as it travels from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic        with_header;
    logic [1:0]  status;
    logic        last;
    logic [63:0] time_value;
    logic [7:0]  type_value;
    logic [31:0] key_len;
    logic [31:0] rec_len;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/lep_front.sv =====
// front part: byte acceptance, header parsing and result classification
`timescale 1ns / 1ps
`default_nettype none

module lep_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_end,
  input  wire logic           cfg_valid,
  input  wire logic [7:0]     cfg_data,
  input  wire logic           q_full,
  output logic                q_push,
  output lep_pkg::item_t      q_item
);

  lep_pkg::phase_t phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic        header_bad, header_bad_next;
  logic        halted, halted_next;
  logic        started, started_next;
  logic [63:0] time_value, time_value_next;
  logic [7:0]  type_value, type_value_next;
  logic [31:0] key_len, key_len_next;
  logic [31:0] rec_len, rec_len_next;
  logic [31:0] remaining, remaining_next;
  logic [7:0]  expected_version;
  logic        fire;
  logic        res_valid;
  lep_pkg::item_t res;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign q_push   = fire && res_valid;
  assign q_item   = res;

  // version register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= lep_pkg::VERSION_RESET;
    end else if (cfg_valid) begin
      expected_version <= cfg_data;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lep_pkg::PH_MAGIC;
      idx        <= '0;
      header_bad <= 1'b0;
      halted     <= 1'b0;
      started    <= 1'b0;
      time_value <= '0;
      type_value <= '0;
      key_len    <= '0;
      rec_len    <= '0;
      remaining  <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      idx        <= idx_next;
      header_bad <= header_bad_next;
      halted     <= halted_next;
      started    <= started_next;
      time_value <= time_value_next;
      type_value <= type_value_next;
      key_len    <= key_len_next;
      rec_len    <= rec_len_next;
      remaining  <= remaining_next;
    end
  end

  // next state and result for the byte on the input
  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    header_bad_next = header_bad;
    halted_next     = halted;
    started_next    = started;
    time_value_next = time_value;
    type_value_next = type_value;
    key_len_next    = key_len;
    rec_len_next    = rec_len;
    remaining_next  = remaining;
    res_valid       = 1'b0;
    res.kind        = lep_pkg::KIND_STATUS;
    res.payload     = 8'd0;
    res.with_header = 1'b1;
    res.status      = lep_pkg::ST_OK;
    res.last        = 1'b0;
    res.time_value  = time_value;
    res.type_value  = type_value;
    res.key_len     = key_len;
    res.rec_len     = rec_len;

    if (halted) begin
      // stream is dead until reset
    end else if (in_end) begin
      // end marker drops any partial entry
      res_valid       = 1'b1;
      res.with_header = 1'b0;
      res.status      = started ? lep_pkg::ST_TAIL : lep_pkg::ST_CLEAN;
      res.last        = 1'b1;
      phase_next      = lep_pkg::PH_MAGIC;
      idx_next        = '0;
      header_bad_next = 1'b0;
      started_next    = 1'b0;
    end else begin
      started_next = 1'b1;
      case (phase)
        lep_pkg::PH_MAGIC: begin
          if (idx == 4'd0) begin
            header_bad_next = (in_byte != lep_pkg::MAGIC_0);
            idx_next        = 4'd1;
          end else if (idx == 4'd1) begin
            header_bad_next = header_bad || (in_byte != lep_pkg::MAGIC_1);
            idx_next        = 4'd2;
          end else if (header_bad || (in_byte != expected_version)) begin
            res_valid       = 1'b1;
            res.with_header = 1'b0;
            res.status      = lep_pkg::ST_CORRUPT;
            res.last        = 1'b1;
            halted_next     = 1'b1;
          end else begin
            phase_next      = lep_pkg::PH_TIME;
            idx_next        = '0;
            time_value_next = '0;
          end
        end
        lep_pkg::PH_TIME: begin
          time_value_next[{idx[2:0], 3'b000} +: 8] = in_byte;
          if (idx[2:0] == 3'd7) begin
            phase_next = lep_pkg::PH_TYPE;
            idx_next   = '0;
          end else begin
            idx_next = idx + 4'd1;
          end
        end
        lep_pkg::PH_TYPE: begin
          type_value_next = in_byte;
          phase_next      = lep_pkg::PH_KLEN;
          idx_next        = '0;
          key_len_next    = '0;
          rec_len_next    = '0;
        end
        lep_pkg::PH_KLEN: begin
          key_len_next[{idx[1:0], 3'b000} +: 8] = in_byte;
          if (idx[1:0] == 2'd3) begin
            remaining_next = key_len_next;
            phase_next     = (key_len_next != 32'd0) ? lep_pkg::PH_KEY : lep_pkg::PH_RLEN;
            idx_next       = '0;
          end else begin
            idx_next = idx + 4'd1;
          end
        end
        lep_pkg::PH_KEY: begin
          res_valid      = 1'b1;
          res.kind       = lep_pkg::KIND_KEY;
          res.payload    = in_byte;
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next = lep_pkg::PH_RLEN;
            idx_next   = '0;
          end
        end
        lep_pkg::PH_RLEN: begin
          rec_len_next[{idx[1:0], 3'b000} +: 8] = in_byte;
          if (idx[1:0] == 2'd3) begin
            idx_next = '0;
            if (rec_len_next == 32'd0) begin
              // empty record closes the entry at once
              res_valid       = 1'b1;
              res.last        = 1'b1;
              res.rec_len     = rec_len_next;
              phase_next      = lep_pkg::PH_MAGIC;
              header_bad_next = 1'b0;
              started_next    = 1'b0;
            end else begin
              remaining_next = rec_len_next;
              phase_next     = lep_pkg::PH_REC;
            end
          end else begin
            idx_next = idx + 4'd1;
          end
        end
        lep_pkg::PH_REC: begin
          res_valid      = 1'b1;
          res.kind       = lep_pkg::KIND_REC;
          res.payload    = in_byte;
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            res.last        = 1'b1;
            phase_next      = lep_pkg::PH_MAGIC;
            idx_next        = '0;
            header_bad_next = 1'b0;
            started_next    = 1'b0;
          end
        end
        default: begin
          phase_next      = lep_pkg::PH_MAGIC;
          idx_next        = '0;
          header_bad_next = 1'b0;
          started_next    = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lep_queue.sv =====
// short result queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module lep_queue #(
  parameter int DEPTH = lep_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lep_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output lep_pkg::item_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lep_pkg::item_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lep_back.sv =====
// back part: result formatting and output register
`timescale 1ns / 1ps
`default_nettype none

module lep_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_not_empty,
  input  wire lep_pkg::item_t q_head,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [151:0]        m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);

  logic load;

  assign load  = q_not_empty && (!m_tvalid || m_tready);
  assign q_pop = load;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload, header fields cleared for bare status results
  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= q_head.kind;
      m_tlast <= q_head.last;
      if (q_head.with_header) begin
        m_tdata <= {6'd0, q_head.status, q_head.rec_len, q_head.key_len,
                    q_head.type_value, q_head.time_value, q_head.payload};
      end else begin
        m_tdata <= {6'd0, q_head.status, 136'd0, q_head.payload};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/log_entry_stream_parser.sv =====
// top level of the log entry stream parser
// Usage:
//   s_* carries the log stream, one byte per transfer; s_tuser set marks
//   the end of available data and the byte is then ignored.
//   m_* carries key bytes, record bytes and status-only results, each with
//   header fields (zero for end/corrupt status); m_tlast closes an entry or stream.
//   cfg_* writes the expected version byte; write only while idle (unchecked).
// Timing:
//   one byte per cycle sustained while the queue is not full; the transfer
//   edge writes the byte's result into the queue and the output register
//   takes it once it is free. header bytes give no result, except a corrupt
//   status or an empty record's closing result; a corrupt header halts the
//   parser until reset, with later bytes still taken and dropped.
// Reset:
//   rst clears the parser to the start of an entry, empties the queue,
//   drops any waiting result and sets the expected version to 1.
// Stall:
//   while m_tready is low the output holds and the queue fills; once it
//   is full s_tready drops until the receiver takes a result.
`timescale 1ns / 1ps
`default_nettype none

module log_entry_stream_parser #(
  parameter int QUEUE_DEPTH = lep_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // data_byte
  input  wire logic         s_tuser,   // end_marker
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // payload_byte, timestamp, entry_type, key_length, record_length, status, zero pad
  output logic [151:0]      m_tdata,
  output logic [1:0]        m_tuser,   // result_kind
  output logic              m_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data   // expected_version
);

  logic           q_full, q_push, q_pop, q_not_empty;
  lep_pkg::item_t q_in, q_head;

  assign cfg_ready = 1'b1;

  // front: parse bytes
  lep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_end    (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // queue between the two sides
  lep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: deliver results
  lep_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire
